### rtl/crs_pkg.sv
`timescale 1ns / 1ps
// crs_pkg: shared types, codes and constants of the command retry session.
// No dependencies; imported by every module of the block.
package crs_pkg;

  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_TICK  = 2'd1;
  localparam logic [1:0] REQ_RX    = 2'd2;

  localparam logic [1:0] KIND_SEND = 2'd0;
  localparam logic [1:0] KIND_OK   = 2'd1;
  localparam logic [1:0] KIND_FAIL = 2'd2;

  localparam logic [7:0]  BCAST_ADDR = 8'hFF;
  localparam logic [7:0]  PKT_LEN    = 8'd3;
  localparam logic [15:0] TICK_MAX   = 16'hFFFF;

  localparam int IN_W   = 80;
  localparam int OUT_W  = 48;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // register index 0 sits at byte address 0; paddr[2] selects the index
  localparam logic REG_STATION = 1'b0;

  // first declared member is the most significant
  typedef struct packed {
    logic [7:0]  rx_data;
    logic [7:0]  rx_command;
    logic [7:0]  rx_address;
    logic [7:0]  rx_length;
    logic [7:0]  attempts;
    logic [15:0] wait_ticks;
    logic [7:0]  expected_reply;
    logic [7:0]  data;
    logic [7:0]  cmd;
  } in_item_t;

  typedef struct packed {
    logic [15:0] turnaround;
    logic [7:0]  reply_data;
    logic [7:0]  tx_data;
    logic [7:0]  tx_command;
    logic [7:0]  tx_address;
  } out_item_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    out_item_t  item;
  } result_t;

endpackage

### rtl/command_retry_ack_session_top.sv
`timescale 1ns / 1ps
// command_retry_ack_session_top: stop-and-wait command session with retries.
// Depends on crs_pkg, crs_in_reg, crs_engine, crs_out_reg.
//
//  channel  | dir | tdata / data                                      | tuser
//  in_      | in  | cmd,data,expected_reply,wait_ticks,attempts,       | req_type
//           |     | rx_length,rx_address,rx_command,rx_data (80b)     |
//  out_     | out | tx_address,tx_command,tx_data,reply_data,          | out_kind
//           |     | turnaround (48b)                                  |
//  cfg (APB)| in  | reg 0 station_address at 0x0                      | -
//
// One word per clock unless a waiting result stalls the output: input register,
// one pass of decision logic, result register.
// A stalled output blocks the decision stage only while a result is waiting.
// Synchronous active-low reset: idle session, station address 0.
module command_retry_ack_session_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [crs_pkg::IN_W-1:0]    in_tdata,   // cmd,data,expected_reply,wait_ticks,
                                                  // attempts,rx_length,rx_address,
                                                  // rx_command,rx_data
  input  logic [1:0]                  in_tuser,   // req_type
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [crs_pkg::OUT_W-1:0]   out_tdata,  // tx_address,tx_command,tx_data,
                                                  // reply_data,turnaround
  output logic [1:0]                  out_tuser,  // out_kind
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [crs_pkg::ADDR_W-1:0]  paddr,
  input  logic [crs_pkg::DATA_W-1:0]  pwdata,
  output logic [crs_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import crs_pkg::*;

  logic      item_valid;
  logic [1:0] item_type;
  in_item_t  item;
  result_t   res;
  logic      slot_free;
  logic      advance;
  logic      station_we;
  logic [7:0] station;
  out_item_t out_item;

  assign advance    = item_valid && slot_free;
  assign pready     = 1'b1;
  assign station_we = psel && penable && pwrite && pready && (paddr[2] == REG_STATION);
  assign prdata     = (paddr[2] == REG_STATION) ? {{(DATA_W-8){1'b0}}, station} : '0;
  assign out_tdata  = out_item;

  crs_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_item    (in_item_t'(in_tdata)),
    .advance    (advance),
    .item_valid (item_valid),
    .item_type  (item_type),
    .item       (item)
  );

  crs_engine u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .advance       (advance),
    .item_type     (item_type),
    .item          (item),
    .station_we    (station_we),
    .station_wdata (pwdata[7:0]),
    .station       (station),
    .res           (res)
  );

  crs_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .res        (res),
    .slot_free  (slot_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_kind   (out_tuser),
    .out_item   (out_item)
  );

endmodule

### rtl/crs_in_reg.sv
`timescale 1ns / 1ps
// crs_in_reg: input register stage holding one accepted word.
// Depends on crs_pkg.
module crs_in_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [1:0]          in_tuser,
  input  crs_pkg::in_item_t   in_item,
  input  logic                advance,
  output logic                item_valid,
  output logic [1:0]          item_type,
  output crs_pkg::in_item_t   item
);
  import crs_pkg::*;

  logic       valid_r;
  logic [1:0] type_r;
  in_item_t   item_r;

  assign in_tready = !valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      type_r <= in_tuser;
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item_type  = type_r;
  assign item       = item_r;

endmodule

### rtl/crs_engine.sv
`timescale 1ns / 1ps
// crs_engine: session state, station address register and per-word decision.
// Depends on crs_pkg.
module crs_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  logic [1:0]          item_type,
  input  crs_pkg::in_item_t   item,
  input  logic                station_we,
  input  logic [7:0]          station_wdata,
  output logic [7:0]          station,
  output crs_pkg::result_t    res
);
  import crs_pkg::*;

  logic        active_r, active_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [7:0]  data_r, data_nxt;
  logic [7:0]  awaited_r, awaited_nxt;
  logic [15:0] interval_r, interval_nxt;
  logic [7:0]  tries_r, tries_nxt;
  logic [15:0] ticks_r, ticks_nxt;
  logic [7:0]  station_r;
  logic [15:0] ticks_inc;
  logic        addr_ok;

  assign ticks_inc = (ticks_r != TICK_MAX) ? ticks_r + 16'd1 : ticks_r;
  assign addr_ok   = (item.rx_address == station_r) || (item.rx_address == BCAST_ADDR);

  always_comb begin
    active_nxt   = active_r;
    cmd_nxt      = cmd_r;
    data_nxt     = data_r;
    awaited_nxt  = awaited_r;
    interval_nxt = interval_r;
    tries_nxt    = tries_r;
    ticks_nxt    = ticks_r;
    res          = '0;
    case (item_type)
      REQ_START: begin
        active_nxt   = 1'b1;
        cmd_nxt      = item.cmd;
        data_nxt     = item.data;
        awaited_nxt  = item.expected_reply;
        interval_nxt = item.wait_ticks;
        tries_nxt    = (item.attempts == 8'd0) ? 8'd0 : item.attempts - 8'd1;
        ticks_nxt    = '0;
        res.valid    = 1'b1;
        res.kind     = KIND_SEND;
        res.item.tx_address = station_r;
        res.item.tx_command = item.cmd;
        res.item.tx_data    = item.data;
      end
      REQ_TICK: begin
        if (active_r) begin
          ticks_nxt = ticks_inc;
          if (ticks_inc >= interval_r) begin
            res.valid = 1'b1;
            if (tries_r != 8'd0) begin
              tries_nxt = tries_r - 8'd1;
              ticks_nxt = '0;
              res.kind  = KIND_SEND;
              res.item.tx_address = station_r;
              res.item.tx_command = cmd_r;
              res.item.tx_data    = data_r;
            end else begin
              active_nxt = 1'b0;
              res.kind   = KIND_FAIL;
            end
          end
        end
      end
      REQ_RX: begin
        if (active_r && item.rx_length == PKT_LEN && addr_ok &&
            item.rx_command == awaited_r) begin
          active_nxt = 1'b0;
          res.valid  = 1'b1;
          res.kind   = KIND_OK;
          res.item.reply_data = item.rx_data;
          res.item.turnaround = ticks_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= 1'b0;
      cmd_r      <= '0;
      data_r     <= '0;
      awaited_r  <= '0;
      interval_r <= '0;
      tries_r    <= '0;
      ticks_r    <= '0;
    end else if (advance) begin
      active_r   <= active_nxt;
      cmd_r      <= cmd_nxt;
      data_r     <= data_nxt;
      awaited_r  <= awaited_nxt;
      interval_r <= interval_nxt;
      tries_r    <= tries_nxt;
      ticks_r    <= ticks_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      station_r <= '0;
    end else if (station_we) begin
      station_r <= station_wdata;
    end
  end

  assign station = station_r;

endmodule

### rtl/crs_out_reg.sv
`timescale 1ns / 1ps
// crs_out_reg: result register between the engine and the output channel.
// Depends on crs_pkg.
module crs_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  crs_pkg::result_t    res,
  output logic                slot_free,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [1:0]          out_kind,
  output crs_pkg::out_item_t  out_item
);
  import crs_pkg::*;

  logic       valid_r;
  logic [1:0] kind_r;
  out_item_t  item_r;

  assign slot_free = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance && res.valid) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      kind_r <= res.kind;
      item_r <= res.item;
    end
  end

  assign out_tvalid = valid_r;
  assign out_kind   = kind_r;
  assign out_item   = item_r;

endmodule

### rtl/crs_checker.sv
`timescale 1ns / 1ps
// crs_checker: port-level assertions for the command retry session top level.
// Depends on crs_pkg; bound to command_retry_ack_session_top.
module crs_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [crs_pkg::OUT_W-1:0]  out_tdata,
  input logic [1:0]                 out_tuser
);
  import crs_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output word changed while stalled");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser == KIND_SEND || out_tuser == KIND_OK || out_tuser == KIND_FAIL)
    else $error("unused result kind");

  a_fail_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_FAIL |-> out_tdata == '0)
    else $error("failure word carries data");

  a_send_no_reply: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_SEND |-> out_tdata[OUT_W-1:24] == '0)
    else $error("send word carries reply fields");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind command_retry_ack_session_top crs_checker u_crs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
